FILE: rtl/core/rncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rncc_pkg: shared types and codes of the Roman numeral checker/converter
// Holds the decoded character format passed from front to back, the decimal
// rank codes and the result status codes.
// ----------------------------------------------------------------------------
package rncc_pkg;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RANK_W   = 3;
  localparam int unsigned LEVEL_W  = 2;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // ASCII codes of the numeral characters
  localparam logic [SYMBOL_W-1:0] SYM_M = 8'h4D;
  localparam logic [SYMBOL_W-1:0] SYM_D = 8'h44;
  localparam logic [SYMBOL_W-1:0] SYM_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] SYM_L = 8'h4C;
  localparam logic [SYMBOL_W-1:0] SYM_X = 8'h58;
  localparam logic [SYMBOL_W-1:0] SYM_V = 8'h56;
  localparam logic [SYMBOL_W-1:0] SYM_I = 8'h49;

  // Decimal rank codes; a character decade uses the low two bits
  localparam logic [RANK_W-1:0] RANK_THOUSANDS = 3'd0;
  localparam logic [RANK_W-1:0] RANK_HUNDREDS  = 3'd1;
  localparam logic [RANK_W-1:0] RANK_TENS      = 3'd2;
  localparam logic [RANK_W-1:0] RANK_UNITS     = 3'd3;
  localparam logic [RANK_W-1:0] RANK_DONE      = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_LEGIT      = 2'd0,
    STATUS_BAD_SYMBOL = 2'd1,
    STATUS_NOT_LEGIT  = 2'd2
  } status_t;

  // One classified character
  typedef struct packed {
    logic               sym_ok;
    logic [LEVEL_W-1:0] level;
    logic               five;
    logic               last;
  } item_t;

endpackage : rncc_pkg
`default_nettype wire

FILE: rtl/core/rncc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rncc_front: input side of the checker
// Classifies each incoming character into decade and kind and pushes it into
// the queue; takes a transfer whenever the queue has room.
// ----------------------------------------------------------------------------
module rncc_front
  import rncc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [SYMBOL_W-1:0] s_axis_tdata,
  input  wire logic                s_axis_tlast,
  input  wire logic                q_full,
  output logic                     q_push,
  output item_t                    q_item
);

  logic               sym_ok;
  logic [LEVEL_W-1:0] level;
  logic               five;
  logic               rst_seen;

  // Hold off the first transfer until the reset has been seen
  always_ff @(posedge clk) begin
    if (rst) begin
      rst_seen <= 1'b0;
    end else begin
      rst_seen <= 1'b1;
    end
  end

  always_comb begin
    sym_ok = 1'b1;
    level  = RANK_THOUSANDS[LEVEL_W-1:0];
    five   = 1'b0;
    case (s_axis_tdata)
      SYM_M: begin level = RANK_THOUSANDS[LEVEL_W-1:0]; five = 1'b0; end
      SYM_D: begin level = RANK_HUNDREDS[LEVEL_W-1:0];  five = 1'b1; end
      SYM_C: begin level = RANK_HUNDREDS[LEVEL_W-1:0];  five = 1'b0; end
      SYM_L: begin level = RANK_TENS[LEVEL_W-1:0];      five = 1'b1; end
      SYM_X: begin level = RANK_TENS[LEVEL_W-1:0];      five = 1'b0; end
      SYM_V: begin level = RANK_UNITS[LEVEL_W-1:0];     five = 1'b1; end
      SYM_I: begin level = RANK_UNITS[LEVEL_W-1:0];     five = 1'b0; end
      default: begin sym_ok = 1'b0; end
    endcase
  end

  assign s_axis_tready = rst_seen && !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_item.sym_ok = sym_ok;
    q_item.level  = level;
    q_item.five   = five;
    q_item.last   = s_axis_tlast;
  end

endmodule : rncc_front
`default_nettype wire

FILE: rtl/core/rncc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rncc_fifo: short queue of classified characters
// Register-based first-in first-out store; push and pop may coincide.
// ----------------------------------------------------------------------------
module rncc_fifo
  import rncc_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : rncc_fifo
`default_nettype wire

FILE: rtl/core/rncc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rncc_back: numeral rule engine and result register
// Applies one queued character per cycle to the rank, counts and running sum;
// a last character waits for a free output register and loads the result.
// ----------------------------------------------------------------------------
module rncc_back
  import rncc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  item_t                   q_item,
  output logic                    q_pop,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [15:0]             m_axis_tdata,
  output logic [STATUS_W-1:0]     m_axis_tuser
);

  function automatic logic [VALUE_W-1:0] unit_value(input logic [LEVEL_W-1:0] r);
    logic [VALUE_W-1:0] v;
    case (r)
      RANK_THOUSANDS[LEVEL_W-1:0]: v = 12'd1000;
      RANK_HUNDREDS[LEVEL_W-1:0]:  v = 12'd100;
      RANK_TENS[LEVEL_W-1:0]:      v = 12'd10;
      default:                     v = 12'd1;
    endcase
    return v;
  endfunction

  logic [RANK_W-1:0]  rank,     rank_next;
  logic [1:0]         unit_run, unit_run_next;
  logic               five_seen, five_seen_next;
  logic [VALUE_W-1:0] sum,      sum_next;
  logic               bad,      bad_next;
  logic               fail,     fail_next;

  logic [RANK_W-1:0]  rank_e;
  logic [1:0]         run_e;
  logic               five_e;
  logic [RANK_W-1:0]  lvl_x;
  logic [VALUE_W-1:0] u;

  logic               out_free;
  status_t            res_status;
  logic [VALUE_W-1:0] res_value;
  status_t            out_status;
  logic [VALUE_W-1:0] out_value;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  // Only a string's final character needs room in the output register
  assign q_pop    = q_valid && (!q_item.last || out_free);

  assign lvl_x = {1'b0, q_item.level};

  // Drop to the character's decade when it lies below the current rank
  always_comb begin
    if (lvl_x > rank) begin
      rank_e = lvl_x;
      run_e  = 2'd0;
      five_e = 1'b0;
    end else begin
      rank_e = rank;
      run_e  = unit_run;
      five_e = five_seen;
    end
  end

  assign u = unit_value(rank_e[LEVEL_W-1:0]);

  always_comb begin
    rank_next      = rank;
    unit_run_next  = unit_run;
    five_seen_next = five_seen;
    sum_next       = sum;
    bad_next       = bad;
    fail_next      = fail;
    if (!q_item.sym_ok) begin
      bad_next = 1'b1;
    end else if (fail || bad) begin
      // frozen after a failure
    end else if (rank == RANK_DONE) begin
      fail_next = 1'b1;
    end else begin
      rank_next      = rank_e;
      unit_run_next  = run_e;
      five_seen_next = five_e;
      if (lvl_x < rank_e) begin
        // higher decade: ten-times pair after a single unit only
        if ((lvl_x + 3'd1) == rank_e && !q_item.five && run_e == 2'd1 && !five_e) begin
          sum_next       = sum + {u[VALUE_W-4:0], 3'b000};
          rank_next      = rank_e + 3'd1;
          unit_run_next  = 2'd0;
          five_seen_next = 1'b0;
        end else begin
          fail_next = 1'b1;
        end
      end else if (!q_item.five) begin
        if (run_e == 2'd3) begin
          fail_next = 1'b1;
        end else begin
          sum_next      = sum + u;
          unit_run_next = run_e + 2'd1;
        end
      end else if (run_e > 2'd1 || five_e) begin
        fail_next = 1'b1;
      end else if (run_e == 2'd1) begin
        // subtractive five pair
        sum_next       = sum + {u[VALUE_W-2:0], 1'b0} + u;
        rank_next      = rank_e + 3'd1;
        unit_run_next  = 2'd0;
        five_seen_next = 1'b0;
      end else begin
        sum_next       = sum + {u[VALUE_W-3:0], 2'b00} + u;
        five_seen_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (bad_next) begin
      res_status = STATUS_BAD_SYMBOL;
      res_value  = '0;
    end else if (fail_next) begin
      res_status = STATUS_NOT_LEGIT;
      res_value  = '0;
    end else begin
      res_status = STATUS_LEGIT;
      res_value  = sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank      <= RANK_THOUSANDS;
      unit_run  <= 2'd0;
      five_seen <= 1'b0;
      sum       <= '0;
      bad       <= 1'b0;
      fail      <= 1'b0;
    end else if (q_pop) begin
      if (q_item.last) begin
        // clear for the next string
        rank      <= RANK_THOUSANDS;
        unit_run  <= 2'd0;
        five_seen <= 1'b0;
        sum       <= '0;
        bad       <= 1'b0;
        fail      <= 1'b0;
      end else begin
        rank      <= rank_next;
        unit_run  <= unit_run_next;
        five_seen <= five_seen_next;
        sum       <= sum_next;
        bad       <= bad_next;
        fail      <= fail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      out_status <= res_status;
      out_value  <= res_value;
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {4'b0000, out_value};

endmodule : rncc_back
`default_nettype wire

FILE: rtl/core/roman_numeral_check_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roman_numeral_check_convert: streaming Roman numeral checker and converter
// Checks the notation of a Roman numeral given one character per transfer and
// returns its value, or an error status, at the end of each string.
// ----------------------------------------------------------------------------
// Feed the numeral one ASCII character per input transfer, with tlast set on
// its final character. Exactly one result transfer follows each string: tuser
// carries the status (legit, invalid symbol present, notation not legit; an
// invalid symbol wins over a notation error) and tdata the value, which is
// zero unless the string is legit. Subtractive pairs (IV, IX, XL, XC, CD, CM)
// are accepted, a fourth repeated unit numeral is rejected, and state clears
// after each string. The block sustains one character per clock cycle while
// the queue and the output register do not hold it back: the rule engine
// updates rank, counts and running sum per character. A result is offered
// once the final character has passed the queue and its result is loaded
// into the output register. The front classifies characters into a queue of
// QUEUE_DEPTH entries, so characters keep flowing in while a result waits on
// the output, until the queue fills; only a string's final character waits
// for room in the output register. Input is held off until reset has ended.
// ----------------------------------------------------------------------------
module roman_numeral_check_convert
  import rncc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Character input
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [SYMBOL_W-1:0] s_axis_tdata,   // [7:0] symbol
  input  wire logic                s_axis_tlast,   // last character of the string
  // Result output
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [15:0]              m_axis_tdata,   // [11:0] value, [15:12] zero
  output logic [STATUS_W-1:0]      m_axis_tuser    // [1:0] status
);

  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  // Classify each character and push it into the queue
  rncc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  // Decouple the input side from output stalls
  rncc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Apply the notation rules and hold the result for the output transfer
  rncc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule : roman_numeral_check_convert
`default_nettype wire

FILE: bench/roman_numeral_check_convert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_check_convert_test: self-checking bench for the numeral checker
// Feeds Roman numeral strings one character per transfer and checks every
// result against a typed value or an in-bench model of the rank and count
// rules. A short table of directed strings comes first, then random numerals,
// broken ones and noise, random gaps on both streams, one long output hold-off.
// ----------------------------------------------------------------------------
module roman_numeral_check_convert_test;
  import rncc_pkg::*;

  localparam logic [7:0] CH_I = "I";
  localparam logic [7:0] CH_V = "V";
  localparam logic [7:0] CH_X = "X";
  localparam logic [7:0] CH_L = "L";
  localparam logic [7:0] CH_C = "C";
  localparam logic [7:0] CH_D = "D";
  localparam logic [7:0] CH_M = "M";

  localparam int TARGET_CHARS = 900;
  localparam int LONG_HOLD    = 300;   // output hold-off that fills the block
  localparam int HOLD_AFTER   = 30;    // results seen before the long hold
  localparam int DRAIN_LIMIT  = 2000;
  localparam int SETTLE       = 10;

  // One character transfer, with an optional hand-written result
  typedef struct packed {
    logic [7:0]  sym;
    logic        last;
    logic        typed;
    status_t     status;
    logic [11:0] value;
  } char_row_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] value;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SYMBOL_W-1:0] s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  char_row_t  char_table[$];
  logic [7:0] numeral_q[$];
  result_t    due_results[$];

  int mismatches   = 0;
  int results_seen = 0;

  // Model state of the rule engine
  logic [2:0]  cur_rank;
  logic [1:0]  unit_count;
  logic        five_flag;
  logic [11:0] sum_acc;
  logic        saw_bad;
  logic        notation_bad;

  int rank_weight[4] = '{1000, 100, 10, 1};

  roman_numeral_check_convert dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model: advance the rule state by one character; on the final character
  // return the result and clear the state for the next string.
  // --------------------------------------------------------------------------
  task automatic clear_numeral_state();
    cur_rank     = RANK_THOUSANDS;
    unit_count   = 2'd0;
    five_flag    = 1'b0;
    sum_acc      = 12'd0;
    saw_bad      = 1'b0;
    notation_bad = 1'b0;
  endtask

  task automatic convert_char(input logic [7:0] sym, input logic last,
                              output logic has_result, output result_t res);
    logic [2:0] lvl;
    logic       five;
    logic       known;
    int         u;
    known = 1'b1;
    five  = 1'b0;
    lvl   = RANK_THOUSANDS;
    case (sym)
      CH_M: lvl = RANK_THOUSANDS;
      CH_D: begin lvl = RANK_HUNDREDS; five = 1'b1; end
      CH_C: lvl = RANK_HUNDREDS;
      CH_L: begin lvl = RANK_TENS; five = 1'b1; end
      CH_X: lvl = RANK_TENS;
      CH_V: begin lvl = RANK_UNITS; five = 1'b1; end
      CH_I: lvl = RANK_UNITS;
      default: known = 1'b0;
    endcase

    if (!known) begin
      saw_bad = 1'b1;
    end else if (!(notation_bad || saw_bad)) begin
      if (cur_rank > RANK_UNITS) begin
        // anything after a subtractive pair at the units rank
        notation_bad = 1'b1;
      end else begin
        // drop to a lower decade and start its counts afresh
        if (lvl > cur_rank) begin
          cur_rank   = lvl;
          unit_count = 2'd0;
          five_flag  = 1'b0;
        end
        u = rank_weight[cur_rank[1:0]];
        if (lvl < cur_rank) begin
          // ten-times numeral: only right after one unit, no five-type
          if (lvl + 3'd1 == cur_rank && !five && unit_count == 2'd1 && !five_flag) begin
            sum_acc    = 12'(sum_acc + 8 * u);
            cur_rank   = cur_rank + 3'd1;
            unit_count = 2'd0;
            five_flag  = 1'b0;
          end else begin
            notation_bad = 1'b1;
          end
        end else if (!five) begin
          if (unit_count == 2'd3) begin
            notation_bad = 1'b1;
          end else begin
            sum_acc    = 12'(sum_acc + u);
            unit_count = unit_count + 2'd1;
          end
        end else if (unit_count > 2'd1 || five_flag) begin
          notation_bad = 1'b1;
        end else if (unit_count == 2'd1) begin
          sum_acc    = 12'(sum_acc + 3 * u);
          cur_rank   = cur_rank + 3'd1;
          unit_count = 2'd0;
          five_flag  = 1'b0;
        end else begin
          sum_acc   = 12'(sum_acc + 5 * u);
          five_flag = 1'b1;
        end
      end
    end

    has_result = last;
    res        = '{status: STATUS_LEGIT, value: 12'd0};
    if (last) begin
      if (saw_bad)
        res.status = STATUS_BAD_SYMBOL;
      else if (notation_bad)
        res.status = STATUS_NOT_LEGIT;
      else
        res.value = sum_acc;
      clear_numeral_state();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic spell(input string s);
    for (int i = 0; i < s.len(); i++)
      numeral_q.push_back(s[i]);
  endtask

  // Move the pending string into the table, tlast on its final character
  task automatic flush_numeral(input logic typed, input status_t st, input logic [11:0] val);
    for (int i = 0; i < numeral_q.size(); i++)
      char_table.push_back('{sym: numeral_q[i], last: (i == numeral_q.size() - 1),
                             typed: typed, status: st, value: val});
    numeral_q.delete();
  endtask

  task automatic spell_digit(input int d, input logic [7:0] one, input logic [7:0] five,
                             input logic [7:0] ten);
    case (d)
      1, 2, 3: repeat (d) numeral_q.push_back(one);
      4: begin numeral_q.push_back(one); numeral_q.push_back(five); end
      5, 6, 7, 8: begin
        numeral_q.push_back(five);
        repeat (d - 5) numeral_q.push_back(one);
      end
      9: begin numeral_q.push_back(one); numeral_q.push_back(ten); end
      default: ;
    endcase
  endtask

  task automatic spell_value(input int n);
    repeat (n / 1000) numeral_q.push_back(CH_M);
    spell_digit((n / 100) % 10, CH_C, CH_D, CH_M);
    spell_digit((n / 10) % 10, CH_X, CH_L, CH_C);
    spell_digit(n % 10, CH_I, CH_V, CH_X);
  endtask

  function automatic logic [7:0] any_numeral();
    case ($urandom_range(0, 6))
      0: return CH_I;
      1: return CH_V;
      2: return CH_X;
      3: return CH_L;
      4: return CH_C;
      5: return CH_D;
      default: return CH_M;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Reset
  // --------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Character sender: walk the table, take each accepted transfer through the
  // model, then wait for the outstanding results and give the verdict.
  // --------------------------------------------------------------------------
  initial begin : send_chars
    char_row_t row;
    result_t   res;
    logic      has_result;
    logic      burst;
    int        gap;
    int        pick;
    int        idx;
    int        waited;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    clear_numeral_state();

    // Directed strings: single unit, out-of-range bytes, the top value, a
    // fourth repeated unit, a character after a units-rank pair, an invalid
    // symbol winning over a notation error, and a tens-rank pair
    spell("I");          flush_numeral(1'b1, STATUS_LEGIT, 12'd1);
    numeral_q.push_back(8'h00); flush_numeral(1'b1, STATUS_BAD_SYMBOL, 12'd0);
    numeral_q.push_back(8'hFF); flush_numeral(1'b1, STATUS_BAD_SYMBOL, 12'd0);
    spell("MMMCMXCIX");  flush_numeral(1'b1, STATUS_LEGIT, 12'd3999);
    spell("IIII");       flush_numeral(1'b1, STATUS_NOT_LEGIT, 12'd0);
    spell("IVI");        flush_numeral(1'b1, STATUS_NOT_LEGIT, 12'd0);
    spell("VVZ");        flush_numeral(1'b1, STATUS_BAD_SYMBOL, 12'd0);
    spell("XL");         flush_numeral(1'b0, STATUS_LEGIT, 12'd0);

    // Random part: mostly well-formed numerals, the rest broken or noise
    while (char_table.size() < TARGET_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        spell_value(($urandom_range(0, 3) == 0) ? $urandom_range(1, 50)
                                                : $urandom_range(1, 3999));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 7)) numeral_q.push_back(any_numeral());
      end else if (pick < 95) begin
        // break one character of a good numeral
        spell_value($urandom_range(1, 3999));
        idx = $urandom_range(0, numeral_q.size() - 1);
        numeral_q[idx] = (pick < 85) ? 8'($urandom_range(0, 255)) : any_numeral();
      end else begin
        repeat ($urandom_range(1, 4)) numeral_q.push_back(8'($urandom_range(0, 255)));
      end
      flush_numeral(1'b0, STATUS_LEGIT, 12'd0);
    end

    do @(posedge clk); while (rst);

    burst = 1'b0;
    foreach (char_table[i]) begin
      row = char_table[i];
      gap = 0;
      if (!burst) begin
        pick = $urandom_range(0, 99);
        if (pick >= 95)
          gap = $urandom_range(8, 30);
        else if (pick >= 60)
          gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= row.sym;
      s_axis_tlast  <= row.last;
      // hold until the transfer completes
      do @(posedge clk); while (!s_axis_tready);

      convert_char(row.sym, row.last, has_result, res);
      if (has_result) begin
        if (row.typed)
          due_results.push_back('{status: row.status, value: row.value});
        else
          due_results.push_back(res);
        // now and then run a whole string without gaps
        burst = ($urandom_range(0, 3) == 0);
      end
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      mismatches++;
    end

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off so that the queue
  // inside the block fills and input transfers stall.
  // --------------------------------------------------------------------------
  initial begin : pace_results
    logic long_hold_done;
    int   run;
    int   stall;
    int   pick;

    long_hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);

    forever begin
      pick = $urandom_range(0, 99);
      run  = (pick < 80) ? $urandom_range(1, 4) : $urandom_range(20, 120);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);

      pick = $urandom_range(0, 99);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (pick < 50) begin
        stall = 0;
      end else if (pick < 92) begin
        stall = $urandom_range(1, 3);
      end else begin
        stall = $urandom_range(8, 30);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d, value %0d", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        exp_res = due_results.pop_front();
        if (m_axis_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata !== {4'b0000, exp_res.value}) begin
          $error("value: expected %0d, got %0d", exp_res.value, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  // Safety net against a hung handshake
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rncc_pkg.sv
rtl/core/rncc_front.sv
rtl/core/rncc_fifo.sv
rtl/core/rncc_back.sv
rtl/core/roman_numeral_check_convert.sv
bench/roman_numeral_check_convert_test.sv
